### src/ett_pkg.sv
`default_nettype none
package ett_pkg;

  localparam int unsigned ENTRIES_DEFAULT  = 16;
  localparam int unsigned KEY_BITS_DEFAULT = 48;
  localparam int unsigned KEY_FIELD_W      = 48;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned CNT_W            = 5;
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned REG_IDX_LSB      = 2;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [TIME_W-1:0] TTL_RESET = 32'd1;

  localparam logic [1:0] OP_GENERATE = 2'd0;
  localparam logic [1:0] OP_RENEW    = 2'd1;
  localparam logic [1:0] OP_COUNT    = 2'd2;

  localparam logic [0:0] REG_TTL = 1'b0;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [KEY_FIELD_W-1:0] token_key;
    logic [TIME_W-1:0]      current_time;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] unexpired_count;
    logic             renew_done;
    logic             table_full;
  } out_word_t;

  typedef struct packed {
    logic key_hit;
    logic hit_live;
    logic free_hit;
  } scan_flags_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ett_state_t;

endpackage
`default_nettype wire

### src/ett_table.sv
`default_nettype none
module ett_table #(
  parameter int unsigned TABLE_ENTRIES = ett_pkg::ENTRIES_DEFAULT,
  parameter int unsigned KEY_W = ett_pkg::KEY_BITS_DEFAULT,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [IDX_W-1:0]          rd_addr,
  output logic                           rd_valid,
  output logic [KEY_W-1:0]               rd_key,
  output logic [ett_pkg::TIME_W-1:0]     rd_stamp,
  input  wire logic                      wr_en,
  input  wire logic [IDX_W-1:0]          wr_addr,
  input  wire logic                      wr_valid,
  input  wire logic [KEY_W-1:0]          wr_key,
  input  wire logic [ett_pkg::TIME_W-1:0] wr_stamp
);
  import ett_pkg::*;

  logic              mem_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]  mem_key   [TABLE_ENTRIES];
  logic [TIME_W-1:0] mem_stamp [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_key[wr_addr]   <= wr_key;
      mem_stamp[wr_addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= mem_valid[rd_addr];
      rd_key   <= mem_key[rd_addr];
      rd_stamp <= mem_stamp[rd_addr];
    end
  end

endmodule
`default_nettype wire

### src/ett_scan.sv
`default_nettype none
module ett_scan #(
  parameter int unsigned TABLE_ENTRIES = ett_pkg::ENTRIES_DEFAULT,
  parameter int unsigned KEY_W = ett_pkg::KEY_BITS_DEFAULT,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       issue_v,
  input  wire logic [IDX_W-1:0]           issue_idx,
  input  wire logic                       rd_valid,
  input  wire logic [KEY_W-1:0]           rd_key,
  input  wire logic [ett_pkg::TIME_W-1:0] rd_stamp,
  input  wire logic [KEY_W-1:0]           key_q,
  input  wire logic [ett_pkg::TIME_W-1:0] now_q,
  input  wire logic [ett_pkg::TIME_W-1:0] ttl,
  output ett_pkg::scan_flags_t            flags,
  output logic [IDX_W-1:0]                hit_idx,
  output logic [IDX_W-1:0]                free_idx,
  output logic [ett_pkg::CNT_W-1:0]       live_count
);
  import ett_pkg::*;

  logic              data_v_r;
  logic [IDX_W-1:0]  data_idx_r;
  scan_flags_t       flags_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [CNT_W-1:0]  count_r;
  logic [TIME_W:0]   expiry;
  logic              live;
  logic              match;

  // The expiry sum is one bit wider so that it never wraps.
  assign expiry = {1'b0, rd_stamp} + {1'b0, ttl};
  assign live   = rd_valid && (expiry > {1'b0, now_q});
  assign match  = rd_valid && (rd_key == key_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_v_r <= 1'b0;
    end else begin
      data_v_r <= issue_v;
    end
  end

  always_ff @(posedge clk) begin
    data_idx_r <= issue_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      flags_r <= '0;
      count_r <= '0;
    end else if (data_v_r) begin
      if (match && !flags_r.key_hit) begin
        flags_r.key_hit  <= 1'b1;
        flags_r.hit_live <= live;
      end
      if (!live && !flags_r.free_hit) begin
        flags_r.free_hit <= 1'b1;
      end
      if (live && (count_r != COUNT_MAX)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_v_r && match && !flags_r.key_hit) begin
      hit_idx_r <= data_idx_r;
    end
    if (data_v_r && !live && !flags_r.free_hit) begin
      free_idx_r <= data_idx_r;
    end
  end

  assign flags      = flags_r;
  assign hit_idx    = hit_idx_r;
  assign free_idx   = free_idx_r;
  assign live_count = count_r;

endmodule
`default_nettype wire

### src/expiring_token_table_unit.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     in_data (opcode, token_key, current_time)
// out       output     out_valid / out_stall   out_data (unexpired_count, renew_done, table_full)
// cfg       input      psel / penable / pready paddr, pwdata, prdata (time_to_live)
//
// Each word is one pass of reads over the slot memory, one slot a cycle, followed by a drain
// and a finish state; no new word is taken until the current word is back in idle.
// After reset a clearing pass over every slot runs before the first word.
// A new word is taken while a finished result waits in the output register.
// A stalled output holds the following result back in its final cycle.
module expiring_token_table_unit #(
  parameter int unsigned TABLE_ENTRIES = ett_pkg::ENTRIES_DEFAULT,
  parameter int unsigned KEY_BITS = ett_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ett_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ett_pkg::out_word_t                  out_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ett_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ett_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  ett_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] ttl_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              cfg_write;
  logic              rd_en;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_stamp;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_valid;
  scan_flags_t       flags;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  live_count;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TTL) ? ttl_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_write && (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TTL)) begin
      ttl_r <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.token_key[KEY_W-1:0];
      now_r <= in_data.current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_valid      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_valid = 1'b0;
        idx_nxt  = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
          unique case (op_r)
            OP_GENERATE: begin
              wr_en   = flags.key_hit || flags.free_hit;
              wr_addr = flags.key_hit ? hit_idx : free_idx;
              out_data_nxt.table_full = !(flags.key_hit || flags.free_hit);
            end
            OP_RENEW: begin
              wr_en   = flags.key_hit && flags.hit_live;
              wr_addr = hit_idx;
              out_data_nxt.renew_done = flags.key_hit && flags.hit_live;
            end
            OP_COUNT: begin
              out_data_nxt.unexpired_count = live_count;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  ett_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_W(KEY_W)
  ) u_table (
    .clk(clk),
    .rd_en(rd_en),
    .rd_addr(idx_r),
    .rd_valid(rd_valid),
    .rd_key(rd_key),
    .rd_stamp(rd_stamp),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_valid(wr_valid),
    .wr_key(key_r),
    .wr_stamp(now_r)
  );

  ett_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_W(KEY_W)
  ) u_scan (
    .clk(clk),
    .rst_n(rst_n),
    .start(accept),
    .issue_v(rd_en),
    .issue_idx(idx_r),
    .rd_valid(rd_valid),
    .rd_key(rd_key),
    .rd_stamp(rd_stamp),
    .key_q(key_r),
    .now_q(now_r),
    .ttl(ttl_r),
    .flags(flags),
    .hit_idx(hit_idx),
    .free_idx(free_idx),
    .live_count(live_count)
  );

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside the final cycle of a word");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !wr_en)
    else $error("slot memory written during a scan");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.table_full && out_data_r.renew_done))
    else $error("renew and full flags both set");

  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.unexpired_count != '0)
      |-> (!out_data_r.renew_done && !out_data_r.table_full))
    else $error("count result carries another flag");

endmodule
`default_nettype wire
